[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the marquee scroller.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("marquee check failed in the same cycle");

// Next-cycle implication, disabled while reset is asserted.
`define TMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("marquee check failed one cycle later");

`endif

[hw/rtl/tms_pkg.sv]
// Package of the text marquee scroller: sizes, codes, command and status types.
// Used by every module of the block; depends on nothing.
package tms_pkg;

    localparam int DISPLAY_WIDTH = 128;
    localparam int MAX_COPIES    = 32;

    localparam int SPEED_W    = 16;
    localparam int TW_W       = 12;
    localparam int ROW_W      = 8;
    localparam int X_W        = 13;
    localparam int OFF_W      = 14;
    localparam int NOW_W      = 63;
    localparam int TIME_W     = 64;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int US_PER_S  = 1000000;
    localparam int US_PER_MS = 1000;
    localparam int MUL_W     = 10;
    localparam int PROD_W    = DELAY_W + MUL_W;

    localparam int DIV_W       = 20;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int PIX_W       = $clog2(DISPLAY_WIDTH + 1);
    localparam int COPY_CNT_W  = (MAX_COPIES > 2) ? $clog2(MAX_COPIES) : 1;

    localparam int SPEED_RESET = 15;
    localparam int SPEED_RESET_CLAMPED = (SPEED_RESET < 1) ? 1 :
        ((SPEED_RESET > DISPLAY_WIDTH) ? DISPLAY_WIDTH : SPEED_RESET);
    localparam int DUR_RESET = US_PER_S / SPEED_RESET_CLAMPED;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW   = 2'd2;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_ACTIVATE = 2'd1,
        CMD_EXPIRE   = 2'd2,
        CMD_QUERY    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        DIV_DUR,
        DIV_PIX,
        DIV_WRAP
    } t_div_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     cap_in;
        logic     div_start;
        t_div_sel div_sel;
        logic     dur_load;
        logic     act_apply;
        logic     pix_apply;
        logic     wrap_apply;
        logic     emit_init;
        logic     load_copy;
        logic     load_query;
        logic     query_due;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic w_zero;
        logic started;
        logic ge_dur;
        logic wrap_need;
        logic emit_last;
        logic div_done;
    } t_dp_status;

    // Scroll speed limited to 1..DISPLAY_WIDTH.
    function automatic logic [PIX_W-1:0] clamp_speed(input logic [SPEED_W-1:0] speed);
        if (speed == '0) begin
            return PIX_W'(1);
        end
        if (speed > SPEED_W'(DISPLAY_WIDTH)) begin
            return PIX_W'(DISPLAY_WIDTH);
        end
        return speed[PIX_W-1:0];
    endfunction

endpackage

[hw/rtl/tms_div.sv]
// Restoring divider of the marquee scroller, one quotient bit per cycle.
// Depends on tms_pkg for its width.
module tms_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tms_pkg::DIV_W-1:0] i_dividend,
    input  logic [tms_pkg::DIV_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [tms_pkg::DIV_W-1:0] o_quotient,
    output logic [tms_pkg::DIV_W-1:0] o_remainder
);

    logic                          r_busy;
    logic                          r_done;
    logic [tms_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [tms_pkg::DIV_W-1:0]     r_quo;
    logic [tms_pkg::DIV_W-1:0]     r_rem;
    logic [tms_pkg::DIV_W-1:0]     r_dvs;
    logic [tms_pkg::DIV_W:0]       rem_sh;
    logic [tms_pkg::DIV_W:0]       trial;

    assign rem_sh = {r_rem, r_quo[tms_pkg::DIV_W-1]};
    assign trial  = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == tms_pkg::DIV_CNT_W'(tms_pkg::DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!trial[tms_pkg::DIV_W]) begin
                r_rem <= trial[tms_pkg::DIV_W-1:0];
                r_quo <= {r_quo[tms_pkg::DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[tms_pkg::DIV_W-1:0];
                r_quo <= {r_quo[tms_pkg::DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[hw/rtl/tms_dp.sv]
// Datapath of the marquee scroller: registers, time arithmetic, scroll offset,
// copy positions and the result register. Depends on tms_pkg and tms_div.
module tms_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tms_pkg::t_dp_cmd                   i_cmd,
    output tms_pkg::t_dp_status                o_status,
    input  logic [1:0]                         i_command,
    input  logic [tms_pkg::NOW_W-1:0]          i_now_us,
    input  logic [tms_pkg::DELAY_W-1:0]        i_delay_ms,
    input  logic                               i_cfg_we,
    input  logic [tms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tms_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                               o_kind,
    output logic signed [tms_pkg::X_W-1:0]     o_draw_x,
    output logic [tms_pkg::ROW_W-1:0]          o_draw_y,
    output logic                               o_redraw_due,
    output logic                               o_last
);

    logic [tms_pkg::SPEED_W-1:0]  r_speed;
    logic [tms_pkg::TW_W-1:0]     r_width;
    logic [tms_pkg::ROW_W-1:0]    r_row;

    tms_pkg::t_cmd                r_cmd;
    logic [tms_pkg::NOW_W-1:0]    r_now;
    logic [tms_pkg::DELAY_W-1:0]  r_delay;
    logic [tms_pkg::PROD_W-1:0]   r_prod;
    logic [tms_pkg::TIME_W-1:0]   r_elapsed;
    logic                         r_started;

    logic [tms_pkg::TIME_W-1:0]   r_start;
    logic [tms_pkg::TIME_W-1:0]   r_last_upd;
    logic signed [tms_pkg::OFF_W-1:0] r_off;
    logic [tms_pkg::DIV_W-1:0]    r_dur;

    logic signed [tms_pkg::OFF_W-1:0] r_x;
    logic [tms_pkg::COPY_CNT_W-1:0]   r_n;

    logic                         r_out_kind;
    logic signed [tms_pkg::X_W-1:0] r_out_x;
    logic [tms_pkg::ROW_W-1:0]    r_out_y;
    logic                         r_out_due;
    logic                         r_out_last;

    logic [tms_pkg::TIME_W-1:0]   now_ext;
    logic [tms_pkg::TIME_W:0]     diff;
    logic [tms_pkg::PIX_W-1:0]    cs;
    logic signed [tms_pkg::OFF_W-1:0] w_s;
    logic signed [tms_pkg::OFF_W-1:0] wrap_d;
    logic signed [tms_pkg::OFF_W-1:0] off_sub;
    logic signed [tms_pkg::OFF_W-1:0] off_wrap;
    logic signed [tms_pkg::OFF_W-1:0] nx;
    logic                         big;
    logic                         q_gt;
    logic                         moved;
    logic                         more;
    logic [tms_pkg::PIX_W-1:0]    pix;

    logic                         div_done;
    logic [tms_pkg::DIV_W-1:0]    div_dividend;
    logic [tms_pkg::DIV_W-1:0]    div_divisor;
    logic [tms_pkg::DIV_W-1:0]    div_quo;
    logic [tms_pkg::DIV_W-1:0]    div_rem;

    tms_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign now_ext = {1'b0, r_now};
    assign diff    = {1'b0, now_ext} - {1'b0, r_last_upd};
    assign cs      = tms_pkg::clamp_speed(r_speed);
    assign w_s     = $signed({{(tms_pkg::OFF_W - tms_pkg::TW_W){1'b0}}, r_width});
    assign big     = |r_elapsed[tms_pkg::TIME_W-1:tms_pkg::DIV_W];

    // Distance below the left wrap limit; at least 1 whenever a wrap is needed.
    assign wrap_d = -r_off - w_s;

    always_comb begin
        case (i_cmd.div_sel)
            tms_pkg::DIV_DUR: begin
                div_dividend = tms_pkg::DIV_W'(tms_pkg::US_PER_S);
                div_divisor  = tms_pkg::DIV_W'(cs);
            end
            tms_pkg::DIV_PIX: begin
                div_dividend = r_elapsed[tms_pkg::DIV_W-1:0];
                div_divisor  = r_dur;
            end
            tms_pkg::DIV_WRAP: begin
                div_dividend = {{(tms_pkg::DIV_W - tms_pkg::OFF_W){1'b0}}, wrap_d};
                div_divisor  = tms_pkg::DIV_W'(r_width);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '1;
            end
        endcase
    end

    // A large elapsed time always reaches the speed limit, since
    // speed times duration never exceeds one second.
    assign q_gt    = div_quo > tms_pkg::DIV_W'(cs);
    assign pix     = (big || q_gt) ? cs : div_quo[tms_pkg::PIX_W-1:0];
    assign moved   = big || (div_quo != '0);
    assign off_sub = r_off - $signed({{(tms_pkg::OFF_W - tms_pkg::PIX_W){1'b0}}, pix});
    assign off_wrap = (div_rem == '0) ? -w_s : -$signed(div_rem[tms_pkg::OFF_W-1:0]);

    assign nx   = r_x + w_s;
    assign more = (nx < $signed(tms_pkg::OFF_W'(tms_pkg::DISPLAY_WIDTH)))
        && (r_n != tms_pkg::COPY_CNT_W'(tms_pkg::MAX_COPIES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= tms_pkg::SPEED_W'(tms_pkg::SPEED_RESET);
            r_width    <= '0;
            r_row      <= '0;
            r_start    <= '0;
            r_last_upd <= '0;
            r_off      <= '0;
            r_dur      <= tms_pkg::DIV_W'(tms_pkg::DUR_RESET);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tms_pkg::REG_SPEED: r_speed <= i_cfg_wdata[tms_pkg::SPEED_W-1:0];
                    tms_pkg::REG_WIDTH: r_width <= i_cfg_wdata[tms_pkg::TW_W-1:0];
                    tms_pkg::REG_ROW:   r_row   <= i_cfg_wdata[tms_pkg::ROW_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.dur_load) begin
                r_dur <= div_quo;
            end
            if (i_cmd.act_apply) begin
                r_start    <= now_ext + tms_pkg::TIME_W'(r_prod);
                r_last_upd <= now_ext + tms_pkg::TIME_W'(r_prod);
                r_off      <= '0;
            end
            if (i_cmd.pix_apply) begin
                if (moved) begin
                    r_last_upd <= now_ext;
                end
                r_off <= (r_width == '0) ? '0 : off_sub;
            end
            if (i_cmd.wrap_apply) begin
                r_off <= off_wrap;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_cmd   <= tms_pkg::t_cmd'(i_command);
            r_now   <= i_now_us;
            r_delay <= i_delay_ms;
        end
        r_prod    <= tms_pkg::PROD_W'(r_delay) * tms_pkg::PROD_W'(tms_pkg::US_PER_MS);
        r_elapsed <= diff[tms_pkg::TIME_W] ? '0 : diff[tms_pkg::TIME_W-1:0];
        r_started <= now_ext >= r_start;
        if (i_cmd.emit_init) begin
            r_x <= r_off;
            r_n <= '0;
        end
        if (i_cmd.load_copy) begin
            r_out_kind <= 1'b0;
            r_out_x    <= r_x[tms_pkg::X_W-1:0];
            r_out_y    <= r_row;
            r_out_due  <= 1'b0;
            r_out_last <= !more;
            r_x        <= nx;
            r_n        <= r_n + 1'b1;
        end
        if (i_cmd.load_query) begin
            r_out_kind <= 1'b1;
            r_out_x    <= '0;
            r_out_y    <= '0;
            r_out_due  <= i_cmd.query_due;
            r_out_last <= 1'b1;
        end
    end

    assign o_status.cmd       = r_cmd;
    assign o_status.w_zero    = (r_width == '0);
    assign o_status.started   = r_started;
    assign o_status.ge_dur    = big || (r_elapsed[tms_pkg::DIV_W-1:0] >= r_dur);
    assign o_status.wrap_need = r_off < -w_s;
    assign o_status.emit_last = !more;
    assign o_status.div_done  = div_done;

    assign o_kind       = r_out_kind;
    assign o_draw_x     = r_out_x;
    assign o_draw_y     = r_out_y;
    assign o_redraw_due = r_out_due;
    assign o_last       = r_out_last;

endmodule

[hw/rtl/tms_ctrl.sv]
// Controller of the marquee scroller: sequencing of commands, scroll mode and
// the result valid flag. Depends on tms_pkg; drives the datapath by commands.
module tms_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_cfg_we,
    input  logic [tms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  tms_pkg::t_dp_status           i_status,
    output tms_pkg::t_dp_cmd              o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DISPATCH,
        ST_PIX_DIV,
        ST_WRAP_CHK,
        ST_WRAP_DIV,
        ST_EMIT_INIT,
        ST_EMIT,
        ST_DUR_START,
        ST_DUR_WAIT
    } t_state;

    typedef enum logic [1:0] {
        MODE_ACTIVE,
        MODE_SHOULD_EXPIRE,
        MODE_EXPIRED
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_out_valid, n_out_valid;
    logic   speed_wr;
    logic   slot_free;

    assign speed_wr   = i_cfg_we && (i_cfg_index == tms_pkg::REG_SPEED);
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || speed_wr;

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = tms_pkg::DIV_DUR;
        n_state       = r_state;
        n_mode        = r_mode;
        n_out_valid   = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (speed_wr) begin
                    n_state = ST_DUR_START;
                end else if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (i_status.cmd)
                    tms_pkg::CMD_ACTIVATE: begin
                        if (!i_status.w_zero) begin
                            o_cmd.act_apply = 1'b1;
                            n_mode          = MODE_ACTIVE;
                        end
                        n_state = ST_IDLE;
                    end
                    tms_pkg::CMD_EXPIRE: begin
                        if (r_mode != MODE_EXPIRED) begin
                            n_mode = MODE_SHOULD_EXPIRE;
                        end
                        n_state = ST_IDLE;
                    end
                    tms_pkg::CMD_QUERY: begin
                        if (slot_free) begin
                            o_cmd.load_query = 1'b1;
                            o_cmd.query_due  = (r_mode != MODE_EXPIRED)
                                && i_status.started && i_status.ge_dur;
                            n_out_valid      = 1'b1;
                            n_state          = ST_IDLE;
                        end
                    end
                    tms_pkg::CMD_TICK: begin
                        if (r_mode == MODE_SHOULD_EXPIRE) begin
                            n_mode  = MODE_EXPIRED;
                            n_state = ST_IDLE;
                        end else if (r_mode != MODE_ACTIVE || !i_status.started) begin
                            n_state = ST_IDLE;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            o_cmd.div_sel   = tms_pkg::DIV_PIX;
                            n_state         = ST_PIX_DIV;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_PIX_DIV: begin
                o_cmd.div_sel = tms_pkg::DIV_PIX;
                if (i_status.div_done) begin
                    o_cmd.pix_apply = 1'b1;
                    n_state         = ST_WRAP_CHK;
                end
            end
            ST_WRAP_CHK: begin
                if (i_status.w_zero) begin
                    n_state = ST_IDLE;
                end else if (i_status.wrap_need) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = tms_pkg::DIV_WRAP;
                    n_state         = ST_WRAP_DIV;
                end else begin
                    n_state = ST_EMIT_INIT;
                end
            end
            ST_WRAP_DIV: begin
                o_cmd.div_sel = tms_pkg::DIV_WRAP;
                if (i_status.div_done) begin
                    o_cmd.wrap_apply = 1'b1;
                    n_state          = ST_EMIT_INIT;
                end
            end
            ST_EMIT_INIT: begin
                o_cmd.emit_init = 1'b1;
                n_state         = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    o_cmd.load_copy = 1'b1;
                    n_out_valid     = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_DUR_START: begin
                // The speed register takes a new value at this edge; wait for it.
                if (!speed_wr) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DUR_WAIT;
                end
            end
            ST_DUR_WAIT: begin
                if (speed_wr) begin
                    n_state = ST_DUR_START;
                end else if (i_status.div_done) begin
                    o_cmd.dur_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_EXPIRED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

[hw/rtl/text_marquee_scroller_top.sv]
// Top level of the text marquee scroller.
// Depends on tms_pkg, tms_ctrl, tms_dp and, through the datapath, tms_div.
//
// This block keeps the horizontal scroll state of one line of text and, on
// each tick transaction, returns the left x positions of the tiled copies of
// that line across a DISPLAY_WIDTH pixel display, scrolling left at the
// configured pixel-per-second speed and driven by the microsecond time stamp
// that comes with every command. An activate transaction starts scrolling
// after its delay, expire marks the line for retirement on the next tick, and
// query returns one result that tells whether a redraw is due. Items are
// handled one at a time; the input stalls while an item is at work. Expire,
// activate, queries and ticks that produce nothing pass the idle, evaluate
// and dispatch states, a query plus any wait for the result register. A tick
// that scrolls runs the shared 20-bit restoring divider once, a second time
// when the offset wraps past the text width, and then hands out one copy per
// cycle while the output is not stalled, at most MAX_COPIES, the last one
// flagged. Writing the scroll speed register reruns the divider to derive
// the per-pixel duration, which holds the input stalled until the duration
// is loaded. A result waits in an output register, so the next transaction
// can be accepted while the last result is still pending downstream.
module text_marquee_scroller_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_command,
    input  logic [tms_pkg::NOW_W-1:0]          i_now_us,
    input  logic [tms_pkg::DELAY_W-1:0]        i_delay_ms,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_kind,
    output logic signed [tms_pkg::X_W-1:0]     o_draw_x,
    output logic [tms_pkg::ROW_W-1:0]          o_draw_y,
    output logic                               o_redraw_due,
    output logic                               o_last,
    input  logic                               i_cfg_we,
    input  logic [tms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tms_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    // Commands flow from the controller into the datapath, status comes back.
    tms_pkg::t_dp_cmd    dp_cmd;
    tms_pkg::t_dp_status dp_status;

    tms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // The datapath owns the configuration registers, the time and offset
    // state, the divider and the result register.
    tms_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_command    (i_command),
        .i_now_us     (i_now_us),
        .i_delay_ms   (i_delay_ms),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_kind       (o_kind),
        .o_draw_x     (o_draw_x),
        .o_draw_y     (o_draw_y),
        .o_redraw_due (o_redraw_due),
        .o_last       (o_last)
    );

endmodule

[hw/rtl/tms_checker.sv]
// Port-level checker of the marquee scroller, bound to the top level.
// Depends on tms_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module tms_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_kind,
    input logic signed [tms_pkg::X_W-1:0]     o_draw_x,
    input logic [tms_pkg::ROW_W-1:0]          o_draw_y,
    input logic                               o_redraw_due,
    input logic                               o_last
);

    // A stalled result stays offered, its kind, position and last flag unchanged.
    `TMS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_draw_x) && $stable(o_draw_y) && $stable(o_last))

    // A query answer is a single result with zero position fields.
    `TMS_ASSERT_IMP(a_query_shape, i_clk, i_rst_n, o_out_valid && o_kind, o_last && (o_draw_x == '0) && (o_draw_y == '0))

    // Copy results never carry a redraw flag and lie left of the display edge.
    `TMS_ASSERT_IMP(a_copy_shape, i_clk, i_rst_n, o_out_valid && !o_kind, !o_redraw_due && ($signed(o_draw_x) < tms_pkg::DISPLAY_WIDTH))

    // Items are worked one at a time: the input stalls right after a transaction.
    `TMS_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind text_marquee_scroller_top tms_checker u_tms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_kind       (o_kind),
    .o_draw_x     (o_draw_x),
    .o_draw_y     (o_draw_y),
    .o_redraw_due (o_redraw_due),
    .o_last       (o_last)
);

[bench/text_marquee_scroller_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the text marquee scroller top level.
// Depends on tms_pkg and text_marquee_scroller_top; holds its own scroll predictor.

// Operating mode of the scrolling line as the predictor tracks it.
typedef enum logic [1:0] {
    LINE_ACTIVE,
    LINE_SHOULD_EXPIRE,
    LINE_EXPIRED
} t_line_mode;

// One result transaction as it leaves the block.
typedef struct {
    logic                            kind;
    logic signed [tms_pkg::X_W-1:0]  draw_x;
    logic [tms_pkg::ROW_W-1:0]       draw_y;
    logic                            redraw_due;
    logic                            is_last;
} t_marquee_result;

// Scoreboard: mirrors the scroll state, predicts the copies or the redraw
// answer of every accepted command and checks the results in order.
class marquee_scoreboard;
    logic [tms_pkg::SPEED_W-1:0] speed_reg;
    logic [tms_pkg::TW_W-1:0]    text_width;
    logic [tms_pkg::ROW_W-1:0]   baseline;
    t_line_mode                  line_mode;
    logic [tms_pkg::TIME_W-1:0]  start_stamp;
    logic [tms_pkg::TIME_W-1:0]  update_stamp;
    int                          scroll_pos;
    int                          pixel_us;
    t_marquee_result             expected_draws[$];
    int                          errors;

    function new();
        speed_reg    = tms_pkg::SPEED_W'(tms_pkg::SPEED_RESET);
        text_width   = '0;
        baseline     = '0;
        line_mode    = LINE_EXPIRED;
        start_stamp  = '0;
        update_stamp = '0;
        scroll_pos   = 0;
        pixel_us     = tms_pkg::US_PER_S / clamped_rate();
        errors       = 0;
    endfunction

    function int clamped_rate();
        if (speed_reg == 0) return 1;
        if (speed_reg > tms_pkg::DISPLAY_WIDTH) return tms_pkg::DISPLAY_WIDTH;
        return int'(speed_reg);
    endfunction

    function int pending();
        return expected_draws.size();
    endfunction

    // Register write; an index outside the list leaves everything alone.
    function void set_reg(logic [tms_pkg::CFG_IDX_W-1:0] idx,
                          logic [tms_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tms_pkg::REG_SPEED: begin
                speed_reg = data;
                pixel_us  = tms_pkg::US_PER_S / clamped_rate();
            end
            tms_pkg::REG_WIDTH: text_width = data[tms_pkg::TW_W-1:0];
            tms_pkg::REG_ROW:   baseline   = data[tms_pkg::ROW_W-1:0];
            default: ;
        endcase
    endfunction

    function void push_result(logic kind, int x, logic [tms_pkg::ROW_W-1:0] y, logic due,
                              logic fin);
        t_marquee_result r;
        r.kind       = kind;
        r.draw_x     = tms_pkg::X_W'(x);
        r.draw_y     = y;
        r.redraw_due = due;
        r.is_last    = fin;
        expected_draws.push_back(r);
    endfunction

    // Advances the scroll state for one accepted command and queues its results.
    function void note_command(tms_pkg::t_cmd cmd, logic [tms_pkg::NOW_W-1:0] now,
                               logic [tms_pkg::DELAY_W-1:0] delay);
        logic [tms_pkg::TIME_W-1:0] stamp;
        logic [tms_pkg::TIME_W-1:0] elapsed;
        logic [tms_pkg::TIME_W-1:0] pixels;
        logic                       due;
        logic                       more;
        int                         w;
        int                         xpos;
        int                         n;
        int                         shortfall;
        stamp   = {1'b0, now};
        // A time stamp that runs backward counts as no time at all.
        elapsed = (stamp >= update_stamp) ? stamp - update_stamp : '0;
        case (cmd)
            tms_pkg::CMD_ACTIVATE: begin
                if (text_width != 0) begin
                    line_mode    = LINE_ACTIVE;
                    start_stamp  = stamp + tms_pkg::TIME_W'(delay)
                                 * tms_pkg::TIME_W'(tms_pkg::US_PER_MS);
                    update_stamp = start_stamp;
                    scroll_pos   = 0;
                end
            end
            tms_pkg::CMD_EXPIRE: begin
                if (line_mode != LINE_EXPIRED) line_mode = LINE_SHOULD_EXPIRE;
            end
            tms_pkg::CMD_QUERY: begin
                due = (line_mode != LINE_EXPIRED) && (stamp >= start_stamp) &&
                      (elapsed >= tms_pkg::TIME_W'(pixel_us));
                push_result(1'b1, 0, '0, due, 1'b1);
            end
            default: begin
                if (line_mode != LINE_ACTIVE) begin
                    if (line_mode == LINE_SHOULD_EXPIRE) line_mode = LINE_EXPIRED;
                end else if (stamp >= start_stamp) begin
                    pixels = elapsed / tms_pkg::TIME_W'(pixel_us);
                    if (pixels >= 1) update_stamp = stamp;
                    if (pixels > tms_pkg::TIME_W'(clamped_rate())) begin
                        pixels = tms_pkg::TIME_W'(clamped_rate());
                    end
                    w = int'(text_width);
                    if (w == 0) begin
                        // Width cleared while active: the offset is pinned at zero.
                        scroll_pos = 0;
                    end else begin
                        scroll_pos -= int'(pixels);
                        if (scroll_pos < -w) begin
                            shortfall  = -w - scroll_pos;
                            scroll_pos += ((shortfall + w - 1) / w) * w;
                        end
                        xpos = scroll_pos;
                        n    = 0;
                        do begin
                            more = (xpos + w < tms_pkg::DISPLAY_WIDTH)
                                && (n + 1 < tms_pkg::MAX_COPIES);
                            push_result(1'b0, xpos, baseline, 1'b0, !more);
                            n++;
                            xpos += w;
                        end while (more);
                    end
                end
            end
        endcase
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(t_marquee_result got);
        t_marquee_result want;
        if (expected_draws.size() == 0) begin
            $error("unexpected result: kind %0d draw_x %0d", got.kind, got.draw_x);
            errors++;
            return;
        end
        want = expected_draws.pop_front();
        if (got.kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, got.kind);
            errors++;
        end
        if (got.draw_x !== want.draw_x) begin
            $error("draw_x mismatch: expected %0d, actual %0d", want.draw_x, got.draw_x);
            errors++;
        end
        if (got.draw_y !== want.draw_y) begin
            $error("draw_y mismatch: expected %0d, actual %0d", want.draw_y, got.draw_y);
            errors++;
        end
        if (got.redraw_due !== want.redraw_due) begin
            $error("redraw_due mismatch: expected %0d, actual %0d",
                   want.redraw_due, got.redraw_due);
            errors++;
        end
        if (got.is_last !== want.is_last) begin
            $error("last mismatch: expected %0d, actual %0d", want.is_last, got.is_last);
            errors++;
        end
    endfunction
endclass

module text_marquee_scroller_top_tb;

    // Index with no register behind it; writes to it must have no effect.
    localparam logic [tms_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Cycles to let the block finish a command that produces no result before a
    // register write, and the drain time at the end. A scrolling tick that wraps
    // runs the divider twice.
    localparam int SETTLE_CYCLES = 120;
    // Length of the long receiver hold-off used to back the block up.
    localparam int HOLD_CYCLES   = 400;
    // Cycles without any accepted transaction before the run is declared hung.
    // The longest legal quiet spell is the hold-off plus a settle pause.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 45;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic [1:0]                        i_command;
    logic [tms_pkg::NOW_W-1:0]         i_now_us;
    logic [tms_pkg::DELAY_W-1:0]       i_delay_ms;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic                              o_kind;
    logic signed [tms_pkg::X_W-1:0]    o_draw_x;
    logic [tms_pkg::ROW_W-1:0]         o_draw_y;
    logic                              o_redraw_due;
    logic                              o_last;
    logic                              i_cfg_we;
    logic [tms_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [tms_pkg::CFG_DATA_W-1:0]    i_cfg_wdata;

    marquee_scoreboard sb;

    // Stimulus shaping shared between the sender, the receiver and the checker.
    bit gaps_on;
    bit hold_req;
    int hold_left;
    int idle_cycles;
    int items_sent;
    int tick_step_max;

    text_marquee_scroller_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_now_us     (i_now_us),
        .i_delay_ms   (i_delay_ms),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_draw_x     (o_draw_x),
        .o_draw_y     (o_draw_y),
        .o_redraw_due (o_redraw_due),
        .o_last       (o_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side. Outputs are sampled right after the rising edge, before the
    // block's own updates land, so the values seen are the ones that were
    // present at the edge. A result counts when valid was high and our stall
    // was low. The stall for the next cycle is then chosen: random short
    // stalls while gaps are enabled, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        t_marquee_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind       = o_kind;
            got.draw_x     = o_draw_x;
            got.draw_y     = o_draw_y;
            got.redraw_due = o_redraw_due;
            got.is_last    = o_last;
            sb.check_result(got);
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        i_out_stall <= (hold_left > 0) || (gaps_on && $urandom_range(0, 99) < 9);
        if (hold_left > 0) hold_left--;
    end

    // Watchdog: any accepted transaction on either side restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offers one command and returns at the edge where it is accepted. Valid
    // is left high, so a following call keeps it up without a glitch; the
    // caller lowers it when the stream pauses.
    task automatic send_item(tms_pkg::t_cmd cmd, logic [tms_pkg::NOW_W-1:0] now,
                             logic [tms_pkg::DELAY_W-1:0] delay);
        while (gaps_on && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_now_us   <= now;
        i_delay_ms <= delay;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(cmd, now, delay);
        items_sent++;
    endtask

    // Stops offering commands and waits until the block has nothing left to do.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Idles the block, then writes all registers plus the unused index. The
    // speed goes last because it restarts the duration divider.
    task automatic configure(logic [tms_pkg::CFG_DATA_W-1:0] speed,
                             logic [tms_pkg::CFG_DATA_W-1:0] width,
                             logic [tms_pkg::CFG_DATA_W-1:0] row);
        logic [tms_pkg::CFG_IDX_W-1:0]  idx[4];
        logic [tms_pkg::CFG_DATA_W-1:0] val[4];
        idx = '{tms_pkg::REG_WIDTH, tms_pkg::REG_ROW, REG_SPARE, tms_pkg::REG_SPEED};
        val = '{width, row, tms_pkg::CFG_DATA_W'($urandom), speed};
        settle();
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_wdata <= val[i];
            @(posedge i_clk);
            sb.set_reg(idx[i], val[i]);
        end
        i_cfg_we <= 1'b0;
        // Largest step for tick time stamps: three pixel durations.
        tick_step_max = 3 * sb.pixel_us;
    endtask

    // Random time stamp: mostly the full 63-bit range so every bit toggles,
    // sometimes small so low-time behavior is seen too.
    function automatic logic [tms_pkg::NOW_W-1:0] random_stamp();
        if ($urandom_range(0, 3) == 0) return tms_pkg::NOW_W'($urandom);
        return tms_pkg::NOW_W'({$urandom, $urandom});
    endfunction

    // A well-formed scrolling sequence: activate, then ticks with rising time
    // stamps, occasional queries, big jumps, backward steps, and sometimes an
    // expire followed by the ticks that retire the line.
    task automatic run_scroll_burst();
        logic [tms_pkg::NOW_W-1:0]   stamp;
        logic [tms_pkg::DELAY_W-1:0] delay;
        int                          pick;
        stamp = random_stamp();
        delay = ($urandom_range(0, 7) == 0) ? tms_pkg::DELAY_W'($urandom) :
                                              tms_pkg::DELAY_W'($urandom_range(0, 40));
        send_item(tms_pkg::CMD_ACTIVATE, stamp, delay);
        // Start a little before the scroll start so the waiting ticks show up.
        stamp = stamp + tms_pkg::NOW_W'(delay) * tms_pkg::NOW_W'(tms_pkg::US_PER_MS)
              - tms_pkg::NOW_W'($urandom_range(0, 20000));
        repeat ($urandom_range(3, 12)) begin
            pick = $urandom_range(0, 13);
            if (pick == 12) begin
                stamp += tms_pkg::NOW_W'($urandom);
            end else if (pick == 13) begin
                stamp -= tms_pkg::NOW_W'($urandom_range(0, 100000));
            end else begin
                stamp += tms_pkg::NOW_W'($urandom_range(0, tick_step_max));
            end
            if ($urandom_range(0, 4) == 0) begin
                send_item(tms_pkg::CMD_QUERY, stamp, tms_pkg::DELAY_W'($urandom));
            end
            send_item(tms_pkg::CMD_TICK, stamp, tms_pkg::DELAY_W'($urandom));
        end
        if ($urandom_range(0, 2) == 0) begin
            send_item(tms_pkg::CMD_EXPIRE, stamp, tms_pkg::DELAY_W'($urandom));
            if ($urandom_range(0, 1) == 0) begin
                send_item(tms_pkg::CMD_QUERY, stamp, tms_pkg::DELAY_W'($urandom));
            end
            send_item(tms_pkg::CMD_TICK, stamp, tms_pkg::DELAY_W'($urandom));
            send_item(tms_pkg::CMD_TICK, stamp, tms_pkg::DELAY_W'($urandom));
        end
    endtask

    // With hold set, the long receiver hold-off starts right after the
    // registers are written, so the commands of this phase back the block up.
    task automatic run_random_phase(logic [tms_pkg::CFG_DATA_W-1:0] speed,
                                    logic [tms_pkg::CFG_DATA_W-1:0] width,
                                    logic [tms_pkg::CFG_DATA_W-1:0] row,
                                    bit hold = 1'b0);
        int phase_start;
        configure(speed, width, row);
        if (hold) hold_req = 1'b1;
        phase_start = items_sent;
        while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 80) begin
                run_scroll_burst();
            end else begin
                send_item(tms_pkg::t_cmd'($urandom_range(0, 3)), random_stamp(),
                          tms_pkg::DELAY_W'($urandom));
            end
        end
    endtask

    initial begin
        // Every input is known from time zero, with reset asserted.
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_command     = tms_pkg::CMD_TICK;
        i_now_us      = '0;
        i_delay_ms    = '0;
        i_out_stall   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = tms_pkg::REG_SPEED;
        i_cfg_wdata   = '0;
        gaps_on       = 1'b1;
        hold_req      = 1'b0;
        hold_left     = 0;
        idle_cycles   = 0;
        items_sent    = 0;
        sb            = new();
        tick_step_max = 3 * sb.pixel_us;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: zero text width, so activate is ignored and the line
        // stays expired; expire on an expired line changes nothing.
        send_item(tms_pkg::CMD_QUERY, '0, '0);
        send_item(tms_pkg::CMD_TICK, '0, '0);
        send_item(tms_pkg::CMD_ACTIVATE, tms_pkg::NOW_W'(123), tms_pkg::DELAY_W'(5));
        send_item(tms_pkg::CMD_EXPIRE, tms_pkg::NOW_W'(200), '0);
        send_item(tms_pkg::CMD_TICK, tms_pkg::NOW_W'(300), '0);
        send_item(tms_pkg::CMD_QUERY, tms_pkg::NOW_W'(400), '0);

        // Fastest speed, narrow text, top baseline row.
        configure(tms_pkg::CFG_DATA_W'(tms_pkg::DISPLAY_WIDTH), tms_pkg::CFG_DATA_W'(10),
                  tms_pkg::CFG_DATA_W'(255));
        send_item(tms_pkg::CMD_ACTIVATE, tms_pkg::NOW_W'(1000), '0);
        // Before the start time.
        send_item(tms_pkg::CMD_TICK, tms_pkg::NOW_W'(500), '0);
        send_item(tms_pkg::CMD_QUERY, tms_pkg::NOW_W'(500), '0);
        // No motion, full tiling.
        send_item(tms_pkg::CMD_TICK, tms_pkg::NOW_W'(1000), '0);
        // Three pixels.
        send_item(tms_pkg::CMD_TICK, tms_pkg::NOW_W'(1000 + 3 * 7812), '0);
        // Huge gap, clamped, wraps.
        send_item(tms_pkg::CMD_TICK, tms_pkg::NOW_W'(64'd10_000_000_000), '0);
        // Time running backward.
        send_item(tms_pkg::CMD_TICK, tms_pkg::NOW_W'(5000), '0);
        // One pixel due.
        send_item(tms_pkg::CMD_QUERY, tms_pkg::NOW_W'(64'd10_000_007_812), '0);
        send_item(tms_pkg::CMD_EXPIRE, tms_pkg::NOW_W'(64'd10_000_007_812), '0);
        // A pending expiry still draws.
        send_item(tms_pkg::CMD_QUERY, tms_pkg::NOW_W'(64'd10_000_007_812), '0);
        // Retires the line.
        send_item(tms_pkg::CMD_TICK, tms_pkg::NOW_W'(64'd10_000_007_812), '0);
        send_item(tms_pkg::CMD_TICK, tms_pkg::NOW_W'(64'd10_000_020_000), '0);
        send_item(tms_pkg::CMD_QUERY, tms_pkg::NOW_W'(64'd10_000_020_000), '0);
        // Latest stamp, longest delay.
        send_item(tms_pkg::CMD_ACTIVATE, '1, '1);
        send_item(tms_pkg::CMD_QUERY, '1, '0);
        send_item(tms_pkg::CMD_TICK, '1, '1);
        send_item(tms_pkg::CMD_ACTIVATE, '0, '0);
        send_item(tms_pkg::CMD_TICK, tms_pkg::NOW_W'(5 * 7812), '0);

        // Text width cleared while the line is active: nothing is drawn.
        configure(tms_pkg::CFG_DATA_W'(tms_pkg::DISPLAY_WIDTH), '0,
                  tms_pkg::CFG_DATA_W'(255));
        send_item(tms_pkg::CMD_TICK, tms_pkg::NOW_W'(9 * 7812), '0);
        send_item(tms_pkg::CMD_QUERY, tms_pkg::NOW_W'(9 * 7812), '0);

        // One pixel wide text at speed zero: the copy count hits its cap.
        configure('0, tms_pkg::CFG_DATA_W'(1), '0);
        send_item(tms_pkg::CMD_TICK, tms_pkg::NOW_W'(9 * 7812 + 2_000_000), '0);

        // Random phases across speeds and widths, extremes included.
        run_random_phase(tms_pkg::CFG_DATA_W'(15), tms_pkg::CFG_DATA_W'(40),
                         tms_pkg::CFG_DATA_W'(20));
        // A stretch with no idling on either side.
        gaps_on = 1'b0;
        run_random_phase('0, tms_pkg::CFG_DATA_W'(100), tms_pkg::CFG_DATA_W'(255));
        gaps_on = 1'b1;
        run_random_phase('1, '1, tms_pkg::CFG_DATA_W'(128));
        // Long receiver hold-off with many copies per tick, so the output
        // backs up and the input side has to stall.
        run_random_phase(tms_pkg::CFG_DATA_W'(tms_pkg::DISPLAY_WIDTH), tms_pkg::CFG_DATA_W'(1),
                         tms_pkg::CFG_DATA_W'(7), 1'b1);
        run_random_phase(tms_pkg::CFG_DATA_W'(60), tms_pkg::CFG_DATA_W'(3), '0);
        run_random_phase(tms_pkg::CFG_DATA_W'(200), tms_pkg::CFG_DATA_W'(128),
                         tms_pkg::CFG_DATA_W'(63));
        run_random_phase(tms_pkg::CFG_DATA_W'(1), tms_pkg::CFG_DATA_W'(4095),
                         tms_pkg::CFG_DATA_W'(255));
        run_random_phase(tms_pkg::CFG_DATA_W'(100), tms_pkg::CFG_DATA_W'(17),
                         tms_pkg::CFG_DATA_W'(170));

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
